// ===== sv/counting_semaphore_table_top_macros.svh =====
// Assertion macros for the semaphore table's checked top level.
`ifndef COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define CSEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define CSEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csem_pkg.sv =====
// Types and constants shared by the counting semaphore table modules.
package csem_pkg;

  localparam int RID_MAX_W = 4;
  localparam int PID_MAX_W = 16;
  localparam int NUM_INIT_REGS = 4;
  localparam logic [7:0] INIT_COUNT_RESET = 8'd1;
  localparam logic [2:0] RES_IN_USE_RESET = 3'd4;

  localparam logic KIND_WAIT   = 1'b0;
  localparam logic KIND_SIGNAL = 1'b1;

  typedef enum logic [1:0] {
    ACT_TERMINATE = 2'd0,
    ACT_BLOCK     = 2'd1,
    ACT_CONTINUE  = 2'd2,
    ACT_FULL      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_RES_IN_USE = 3'd0,
    REG_INIT_0     = 3'd1,
    REG_INIT_1     = 3'd2,
    REG_INIT_2     = 3'd3,
    REG_INIT_3     = 3'd4
  } reg_idx_e;

  // One classified request on its way from the front end to the back end.
  typedef struct packed {
    logic                 known;
    logic                 kind;
    logic [RID_MAX_W-1:0] rid;
    logic [PID_MAX_W-1:0] pid;
  } req_t;

  // Load of an initial count into the live count of one resource.
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
    logic [7:0] value;
  } cfg_load_t;

endpackage

// ===== sv/csem_ram.sv =====
// Generic single-port RAM with registered read data.
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/csem_front.sv =====
// Front end: takes requests and marks those that name an unknown resource.
module csem_front import csem_pkg::*; #(
  parameter int NUM_RESOURCES = 4,
  parameter int PID_BITS      = 8
) (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [2:0] resource_id_i,
  input  logic [7:0] process_id_i,
  input  logic [2:0] res_in_use_i,
  input  logic       q_full_i,
  output logic       push_o,
  output req_t       req_o
);

  localparam int PidKeep = (PID_BITS < 8) ? PID_BITS : 8;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    req_o       = '0;
    req_o.known = (resource_id_i < res_in_use_i) && (int'(resource_id_i) < NUM_RESOURCES);
    req_o.kind  = kind_i;
    req_o.rid   = RID_MAX_W'(resource_id_i);
    // Only the low PID_BITS of the caller id are kept.
    for (int i = 0; i < PidKeep; i++) begin
      req_o.pid[i] = process_id_i[i];
    end
  end

endmodule

// ===== sv/csem_queue.sv =====
// Two-entry request queue between the front end and the back end.
module csem_queue import csem_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output req_t req_o
);

  req_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign req_o   = ent_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/csem_back.sv =====
// Back end: updates counts and wait queues and holds the result register.
module csem_back import csem_pkg::*; #(
  parameter int NUM_RESOURCES = 4,
  parameter int QUEUE_DEPTH   = 16,
  parameter int PID_BITS      = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  req_t       q_req_i,
  output logic       pop_o,
  input  cfg_load_t  cfg_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] action_o,
  output logic       woken_valid_o,
  output logic [7:0] woken_pid_o
);

  localparam int RidW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int SlotW   = $clog2(QUEUE_DEPTH);
  localparam int Depth   = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PidKeep = (PID_BITS < 8) ? PID_BITS : 8;
  localparam logic signed [9:0] FullLimit = -10'(QUEUE_DEPTH);
  localparam logic signed [9:0] CountMax  = 10'sd255;
  localparam logic [SlotW-1:0]  SlotLast  = SlotW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WAKE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  req_t        item_q;

  logic signed [9:0] cnt_q [NUM_RESOURCES];
  logic [SlotW-1:0]  head_q [NUM_RESOURCES];
  logic [SlotW-1:0]  tail_q [NUM_RESOURCES];

  logic       out_valid_q;
  action_e    out_action_q;
  logic       out_wvalid_q;
  logic [7:0] out_wpid_q;

  logic [RidW-1:0]   rid;
  logic signed [9:0] cur_cnt, wait_cnt, sig_cnt, new_cnt;
  logic [SlotW-1:0]  head_cur, tail_cur, head_nxt, tail_nxt, slot;
  logic              is_wait, full_hit, do_block, do_wake, upd_cnt;
  logic              out_free, exec_fire;
  action_e           action;
  logic [AddrW-1:0]  ram_addr;
  logic [PID_BITS-1:0] ram_rdata;
  logic [7:0]        wake_pid;

  assign rid      = item_q.rid[RidW-1:0];
  assign cur_cnt  = cnt_q[rid];
  assign head_cur = head_q[rid];
  assign tail_cur = tail_q[rid];
  assign head_nxt = (head_cur == SlotLast) ? '0 : head_cur + SlotW'(1);
  assign tail_nxt = (tail_cur == SlotLast) ? '0 : tail_cur + SlotW'(1);

  always_comb begin
    is_wait  = (item_q.kind == KIND_WAIT);
    full_hit = (cur_cnt <= FullLimit);
    wait_cnt = cur_cnt - 10'sd1;
    sig_cnt  = (cur_cnt < CountMax) ? cur_cnt + 10'sd1 : cur_cnt;
    new_cnt  = is_wait ? wait_cnt : sig_cnt;
    do_block = item_q.known && is_wait && !full_hit && (wait_cnt < 10'sd0);
    do_wake  = item_q.known && !is_wait && (sig_cnt <= 10'sd0);
    upd_cnt  = item_q.known && !(is_wait && full_hit);
    if (!item_q.known) begin
      action = ACT_TERMINATE;
    end else if (is_wait && full_hit) begin
      action = ACT_FULL;
    end else if (do_block) begin
      action = ACT_BLOCK;
    end else begin
      action = ACT_CONTINUE;
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign exec_fire = (state_q == S_EXEC) && out_free;
  assign pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign slot      = is_wait ? tail_cur : head_cur;
  assign ram_addr  = AddrW'(int'(rid) * QUEUE_DEPTH + int'(slot));

  csem_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (Depth)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (exec_fire && do_block),
    .re_i    (exec_fire && do_wake),
    .addr_i  (ram_addr),
    .wdata_i (item_q.pid[PID_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    wake_pid = '0;
    for (int i = 0; i < PidKeep; i++) begin
      wake_pid[i] = ram_rdata[i];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = do_wake ? S_WAKE : S_IDLE;
        end
      end
      S_WAKE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_req_i;
    end
    if (exec_fire && !do_wake) begin
      out_action_q <= action;
      out_wvalid_q <= 1'b0;
      out_wpid_q   <= '0;
    end else if (state_q == S_WAKE) begin
      out_action_q <= ACT_CONTINUE;
      out_wvalid_q <= 1'b1;
      out_wpid_q   <= wake_pid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        cnt_q[r]  <= (r < NUM_INIT_REGS) ? signed'(10'(INIT_COUNT_RESET)) : 10'sd0;
        head_q[r] <= '0;
        tail_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((exec_fire && !do_wake) || (state_q == S_WAKE)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.we) begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          if (int'(cfg_i.idx) == r) begin
            cnt_q[r]  <= signed'(10'(cfg_i.value));
            head_q[r] <= '0;
            tail_q[r] <= '0;
          end
        end
      end else if (exec_fire) begin
        if (upd_cnt) begin
          cnt_q[rid] <= new_cnt;
        end
        if (do_block) begin
          tail_q[rid] <= tail_nxt;
        end
        if (do_wake) begin
          head_q[rid] <= head_nxt;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign woken_valid_o = out_wvalid_q;
  assign woken_pid_o   = out_wpid_q;

endmodule

// ===== sv/counting_semaphore_table_top.sv =====
// Top level of the counting semaphore table with per-resource wait queues.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid_i / in_stall_o   kind_i, resource_id_i, process_id_i
//   result    out        out_valid_o / out_stall_i action_o, woken_valid_o, woken_pid_o
//   config    in         APB write (psel, penable) paddr, pwdata, prdata
//
// The back end takes each item from the queue and then executes it; when a SIGNAL releases
// a waiter it also passes through a wake state, as the waiter RAM's read is registered.
// Reset is asynchronous: every count returns to one and every wait queue empties; the waiter
// RAM is not cleared, since a queue only ever reads slots that it has written.
// A stalled result holds in the output register while the back end waits with its next item;
// the two-entry queue keeps taking requests until it fills, and only then is in_stall_o raised.
`include "counting_semaphore_table_top_macros.svh"

module counting_semaphore_table_top import csem_pkg::*; #(
  parameter int NUM_RESOURCES = 4,
  parameter int QUEUE_DEPTH   = 16,
  parameter int PID_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [2:0]  resource_id_i,
  input  logic [7:0]  process_id_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic        woken_valid_o,
  output logic [7:0]  woken_pid_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Writing an initial count also reloads that resource's live
  // count and empties its wait queue, which the back end does on the same edge.
  logic [2:0] res_in_use_q;
  logic [7:0] init_q [NUM_INIT_REGS];
  logic       cfg_wr;
  reg_idx_e   reg_idx;
  cfg_load_t  cfg_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_load       = '0;
    cfg_load.value = pwdata[7:0];
    prdata         = '0;
    unique case (reg_idx)
      REG_RES_IN_USE: begin
        prdata = 32'(res_in_use_q);
      end
      REG_INIT_0: begin
        cfg_load.we  = cfg_wr;
        cfg_load.idx = 2'd0;
        prdata       = 32'(init_q[0]);
      end
      REG_INIT_1: begin
        cfg_load.we  = cfg_wr;
        cfg_load.idx = 2'd1;
        prdata       = 32'(init_q[1]);
      end
      REG_INIT_2: begin
        cfg_load.we  = cfg_wr;
        cfg_load.idx = 2'd2;
        prdata       = 32'(init_q[2]);
      end
      REG_INIT_3: begin
        cfg_load.we  = cfg_wr;
        cfg_load.idx = 2'd3;
        prdata       = 32'(init_q[3]);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_in_use_q <= RES_IN_USE_RESET;
      for (int k = 0; k < NUM_INIT_REGS; k++) begin
        init_q[k] <= INIT_COUNT_RESET;
      end
    end else begin
      if (cfg_wr && (reg_idx == REG_RES_IN_USE)) begin
        res_in_use_q <= pwdata[2:0];
      end
      if (cfg_load.we) begin
        init_q[cfg_load.idx] <= cfg_load.value;
      end
    end
  end

  // Front end classifies each request and drops it into the queue.
  logic q_push, q_full, q_pop, q_empty;
  req_t front_req, back_req;

  csem_front #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .PID_BITS      (PID_BITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .resource_id_i (resource_id_i),
    .process_id_i  (process_id_i),
    .res_in_use_i  (res_in_use_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .req_o         (front_req)
  );

  csem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .req_i   (front_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .req_o   (back_req)
  );

  // Back end owns the counts, the queue pointers, the waiter RAM and the result register.
  csem_back #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PID_BITS      (PID_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_req_i       (back_req),
    .pop_o         (q_pop),
    .cfg_i         (cfg_load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .woken_valid_o (woken_valid_o),
    .woken_pid_o   (woken_pid_o)
  );

  // A released waiter only ever comes with a continuing caller.
  `CSEM_ASSERT_NOW(a_wake_continues, out_valid_o && woken_valid_o,
    action_o == ACT_CONTINUE, "woken process reported with a non-continue action")
  // Results without a released waiter carry a zero process id.
  `CSEM_ASSERT_NOW(a_no_wake_zero_pid, out_valid_o && !woken_valid_o,
    woken_pid_o == 8'd0, "woken_pid_o set without a released waiter")
  // The back end never takes from an empty queue.
  `CSEM_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "request queue popped while empty")
  // A request accepted while the queue is empty is waiting in it on the next cycle.
  `CSEM_ASSERT_NEXT(a_push_reaches_queue, q_push && q_empty && !q_pop,
    !q_empty, "accepted request did not enter the queue")

endmodule

// ===== test/tb_counting_semaphore_table_top.sv =====
// Self-checking testbench for the counting semaphore table top level.
`timescale 1ns / 1ps

module tb_counting_semaphore_table_top;
  import csem_pkg::*;

  // Sizes of the block as built here, and the run limits. Each item costs at most a sender
  // gap, its passage through the back end and a receiver stall, and roughly 1900 items are
  // sent; the cycle limit leaves ample room for them.
  localparam int NUM_SEM      = 4;
  localparam int QDEPTH       = 16;
  localparam int COUNT_CEIL   = 255;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_TAIL    = 250;
  localparam int CYCLE_LIMIT  = 400000;

  // One result of the block, as the table model expects it.
  typedef struct packed {
    action_e    action;
    logic       woken_valid;
    logic [7:0] woken_pid;
  } sem_result_t;

  // The scoreboard keeps its own copy of the semaphore table: the live counts, one ring of
  // waiting process ids per resource and the register settings. Each accepted request is
  // run through that copy at once and the result it must produce is queued for the checker.
  class semaphore_scoreboard;
    int unsigned res_in_use;
    int          count [NUM_SEM];
    logic [7:0]  waiters [NUM_SEM][QDEPTH];
    int          head [NUM_SEM];
    int          tail [NUM_SEM];
    sem_result_t pending [$];
    int          errors;

    function new();
      res_in_use = 4;
      errors = 0;
      for (int r = 0; r < NUM_SEM; r++) begin
        count[r] = 1;
        head[r] = 0;
        tail[r] = 0;
      end
    endfunction

    // A write to an initial count also reloads the live count and empties the queue.
    function void write_reg(reg_idx_e idx, logic [7:0] value);
      int r;
      if (idx == REG_RES_IN_USE) begin
        res_in_use = value & 8'd7;
      end else begin
        r = int'(idx) - int'(REG_INIT_0);
        count[r] = value;
        head[r] = 0;
        tail[r] = 0;
      end
    endfunction

    function void note_request(logic kind, logic [2:0] rid, logic [7:0] pid);
      sem_result_t res;
      int c;
      res.action = ACT_TERMINATE;
      res.woken_valid = 1'b0;
      res.woken_pid = 8'd0;
      if (rid < res_in_use && rid < NUM_SEM) begin
        c = count[rid];
        if (kind == KIND_WAIT) begin
          if (c <= -QDEPTH) begin
            res.action = ACT_FULL;
          end else begin
            c = c - 1;
            count[rid] = c;
            if (c < 0) begin
              waiters[rid][tail[rid]] = pid;
              tail[rid] = (tail[rid] + 1) % QDEPTH;
              res.action = ACT_BLOCK;
            end else begin
              res.action = ACT_CONTINUE;
            end
          end
        end else begin
          if (c < COUNT_CEIL) c = c + 1;
          count[rid] = c;
          if (c <= 0) begin
            res.woken_valid = 1'b1;
            res.woken_pid = waiters[rid][head[rid]];
            head[rid] = (head[rid] + 1) % QDEPTH;
          end
          res.action = ACT_CONTINUE;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [1:0] action, logic woken_valid, logic [7:0] woken_pid);
      sem_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding: action %0d, woken %0d/%0d",
                 $time, action, woken_valid, woken_pid);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (action !== exp.action) begin
        $display("%0t: action mismatch: expected %0d, actual %0d", $time, exp.action, action);
        errors++;
      end
      if (woken_valid !== exp.woken_valid) begin
        $display("%0t: woken_valid mismatch: expected %0d, actual %0d",
                 $time, exp.woken_valid, woken_valid);
        errors++;
      end
      if (woken_pid !== exp.woken_pid) begin
        $display("%0t: woken_pid mismatch: expected %0d, actual %0d",
                 $time, exp.woken_pid, woken_pid);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = KIND_WAIT;
  logic [2:0]  resource_id_i = 3'd0;
  logic [7:0]  process_id_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic        woken_valid_o;
  logic [7:0]  woken_pid_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  semaphore_scoreboard sb = new();

  // Idling switches for both sides, and the long receiver hold-off requested by the sequence.
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int hold_cycles = 0;
  int cycles = 0;

  counting_semaphore_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .resource_id_i(resource_id_i),
    .process_id_i (process_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .woken_valid_o(woken_valid_o),
    .woken_pid_o  (woken_pid_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a run that has not finished by the limit has hung somewhere.
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side. Outputs are sampled at the rising edge, before the block's registers move,
  // so a result counts as taken exactly when valid was high and our stall was low. The stall
  // for the next cycle then comes from a long hold-off, a running burst or a fresh burst.
  initial begin
    int burst_left;
    burst_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(action_o, woken_valid_o, woken_pid_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 11) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one item and holds it steady until the block takes it. Valid is left high on
  // return so that back-to-back items follow one another without valid dropping between them.
  task automatic send_request(input logic kind, input logic [2:0] rid, input logic [7:0] pid);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    resource_id_i <= rid;
    process_id_i <= pid;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, rid, pid);
  endtask

  // Withdraws the request channel and waits until every outstanding result has come back.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // Two-phase register write; the register takes the value at the edge closing the access.
  // The bus then idles before returning, so that a following write starts on a later edge.
  task automatic apb_write(input reg_idx_e idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Initial counts lean towards the ends of the range, where queues fill and counts saturate.
  function automatic logic [7:0] pick_initial_count();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd254;
      4: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // New settings for a phase; the table is idle whenever this is called.
  task automatic reconfigure(input int phase);
    int in_use;
    case (phase % 5)
      0: in_use = 4;
      1: in_use = 1;
      default: in_use = $urandom_range(1, 4);
    endcase
    apb_write(REG_RES_IN_USE, 8'(in_use));
    for (int k = 0; k < NUM_SEM; k++)
      if (phase == 0 || $urandom_range(0, 1) == 1)
        apb_write(reg_idx_e'(int'(REG_INIT_0) + k), pick_initial_count());
  endtask

  initial begin
    int sent;
    int phase;
    int span;
    int wait_pct;
    logic kind;
    logic [2:0] rid;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: four resources, each with one instance. Take it, block on it, hand it
    // back (which wakes the blocked caller), hand it back again, then ask for resources that
    // do not exist.
    send_request(KIND_WAIT, 3'd0, 8'd0);
    send_request(KIND_WAIT, 3'd0, 8'd255);
    send_request(KIND_SIGNAL, 3'd0, 8'h5a);
    send_request(KIND_SIGNAL, 3'd0, 8'ha5);
    send_request(KIND_WAIT, 3'd7, 8'd0);
    send_request(KIND_SIGNAL, 3'd4, 8'd255);

    // Two resources in use, resource 0 empty and resource 1 at its ceiling. A release on a
    // full count saturates, index 2 is now unknown, and seventeen acquires on the empty
    // resource fill its wait queue and then meet the full-queue refusal.
    drain_requests();
    apb_write(REG_RES_IN_USE, 8'd2);
    apb_write(REG_INIT_0, 8'd0);
    apb_write(REG_INIT_1, 8'd255);
    send_request(KIND_SIGNAL, 3'd1, 8'd0);
    send_request(KIND_WAIT, 3'd2, 8'd17);
    for (int i = 0; i <= QDEPTH; i++)
      send_request(KIND_WAIT, 3'd0, 8'(i * 15));
    send_request(KIND_SIGNAL, 3'd0, 8'd1);

    // Random phases. Each phase gets new settings and a bias between acquires and releases,
    // so that some phases pile waiters up to a full queue and others drive counts into
    // saturation. Now and then the request names a resource outside the range in use.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_requests();
      reconfigure(phase);
      // Hold results back for a long stretch while requests keep coming, so that the
      // block's internal queue fills and it has to stall the request channel.
      if (phase == 1 || phase == 6) hold_cycles = 120;
      span = $urandom_range(60, 200);
      case ($urandom_range(0, 2))
        0: wait_pct = 20;
        1: wait_pct = 50;
        default: wait_pct = 80;
      endcase
      for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
        if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
          tx_gaps = 1'b0;
          rx_stalls = 1'b0;
        end
        // Once in the run the sender stops mid-phase until every result is back.
        if (phase == 3 && i == span / 2) drain_requests();
        kind = ($urandom_range(0, 99) < wait_pct) ? KIND_WAIT : KIND_SIGNAL;
        if ($urandom_range(0, 9) == 0)
          rid = 3'($urandom_range(0, 7));
        else
          rid = 3'($urandom_range(0, sb.res_in_use - 1));
        send_request(kind, rid, 8'($urandom_range(0, 255)));
        sent++;
      end
      phase++;
    end

    drain_requests();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
